/* sv/u16550_pkg.sv */
// Shared types and constants for the 16550-style UART register block.
// No dependencies; the register model and the receive FIFO import this package.
package u16550_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  localparam logic [3:0] IER_MASK        = 4'hF;
  localparam logic [7:0] IIR_FIFO_BITS   = 8'hC0;
  localparam logic [7:0] IIR_RX_DATA     = 8'h04;
  localparam logic [7:0] IIR_THR_EMPTY   = 8'h02;
  localparam logic [7:0] IIR_NONE        = 8'h01;
  localparam logic [7:0] LSR_DR          = 8'h01;
  localparam logic [7:0] LSR_HOLD_EMPTY  = 8'h20;
  localparam logic [7:0] LSR_SHIFT_EMPTY = 8'h40;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_ctrl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       one;
    logic [7:0] head_byte;
  } fifo_stat_t;

endpackage

/* sv/u16550_req_if.sv */
// Request channel: one bus read, bus write or received-byte arrival per transaction.
// Depends on nothing.
interface u16550_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] reg_offset;
  logic [7:0] write_data;
  logic [7:0] rx_byte;

  modport source (output valid, command, reg_offset, write_data, rx_byte, input ready);
  modport sink   (input valid, command, reg_offset, write_data, rx_byte, output ready);
endinterface

/* sv/u16550_rsp_if.sv */
// Response channel: one result transaction per request.
// Depends on nothing.
interface u16550_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       addr_error;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       irq;

  modport source (output valid, read_data, addr_error, tx_valid, tx_byte, irq, input ready);
  modport sink   (input valid, read_data, addr_error, tx_valid, tx_byte, irq, output ready);
endinterface

/* sv/uart_16550_register_model.sv */
// 16550-style UART register block: eight byte registers, receive FIFO, interrupt level.
// Depends on u16550_pkg, u16550_req_if, u16550_rsp_if and u16550_rx_fifo.
//
// Each request transaction (bus read, bus write or received byte) yields exactly one
// response transaction. A request is captured in an input register, decoded and applied
// to the register state when it leaves that register, and its result lands in an output
// register that holds the response until it is taken. One request is accepted every
// cycle while the response side keeps up. The receive FIFO holds RX_DEPTH bytes in a
// memory with one write and one read port whose head entry is prefetched each cycle, so
// an RBR read pops in the same cycle. A full FIFO drops arrivals; an empty one reads 0.
module uart_16550_register_model
  import u16550_pkg::*;
#(
  parameter int RX_DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  u16550_req_if.sink   req,
  u16550_rsp_if.source rsp
);

  logic       s1_valid;
  logic [1:0] s1_command;
  logic [7:0] s1_offset;
  logic [7:0] s1_wdata;
  logic [7:0] s1_rx_byte;
  logic       s1_advance;

  logic [3:0] int_enable;
  logic [3:0] int_enable_next;
  logic [7:0] line_control;
  logic [7:0] line_control_next;
  logic [7:0] modem_control;
  logic [7:0] modem_control_next;
  logic [7:0] scratch;
  logic [7:0] scratch_next;
  logic       tx_idle;
  logic       tx_idle_next;

  fifo_ctrl_t fifo_ctrl;
  fifo_stat_t fifo_stat;

  logic [7:0] rd;
  logic       aerr;
  logic       txv;
  logic [7:0] txb;
  logic       irq_next;
  logic       rx_pending_next;
  logic       rx_int;
  logic       tx_int;
  logic [2:0] ix;

  assign s1_advance = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_command <= req.command;
      s1_offset  <= req.reg_offset;
      s1_wdata   <= req.write_data;
      s1_rx_byte <= req.rx_byte;
    end
  end

  u16550_rx_fifo #(
    .RX_DEPTH(RX_DEPTH)
  ) u_rx_fifo (
    .clk (clk),
    .rst (rst),
    .ctrl(fifo_ctrl),
    .stat(fifo_stat)
  );

  assign ix     = s1_offset[2:0];
  assign rx_int = int_enable[0] && !fifo_stat.empty;
  assign tx_int = int_enable[1] && tx_idle;

  always_comb begin
    rd                 = '0;
    aerr               = 1'b0;
    txv                = 1'b0;
    txb                = '0;
    int_enable_next    = int_enable;
    line_control_next  = line_control;
    modem_control_next = modem_control;
    scratch_next       = scratch;
    tx_idle_next       = tx_idle;
    fifo_ctrl.push     = 1'b0;
    fifo_ctrl.pop      = 1'b0;
    fifo_ctrl.wdata    = s1_rx_byte;

    unique case (cmd_t'(s1_command))
      CMD_RX: begin
        fifo_ctrl.push = s1_advance;
      end
      CMD_WRITE: begin
        if (|s1_offset[7:3]) begin
          aerr = 1'b1;
        end else begin
          unique case (ix)
            REG_RBR: begin
              txv          = 1'b1;
              txb          = s1_wdata;
              tx_idle_next = 1'b1;
            end
            REG_IER: int_enable_next    = s1_wdata[3:0] & IER_MASK;
            REG_LCR: line_control_next  = s1_wdata;
            REG_MCR: modem_control_next = s1_wdata;
            REG_SCR: scratch_next       = s1_wdata;
            default: ;
          endcase
        end
      end
      CMD_READ: begin
        if (|s1_offset[7:3]) begin
          aerr = 1'b1;
        end else begin
          unique case (ix)
            REG_RBR: begin
              fifo_ctrl.pop = s1_advance;
              rd            = fifo_stat.empty ? 8'h00 : fifo_stat.head_byte;
            end
            REG_IER: rd = {4'h0, int_enable};
            REG_IIR: begin
              if (rx_int) begin
                rd = IIR_FIFO_BITS | IIR_RX_DATA;
              end else if (tx_int) begin
                rd = IIR_FIFO_BITS | IIR_THR_EMPTY;
              end else begin
                rd = IIR_FIFO_BITS | IIR_NONE;
              end
            end
            REG_LCR: rd = line_control;
            REG_MCR: rd = modem_control;
            REG_LSR: begin
              rd = tx_idle ? (LSR_HOLD_EMPTY | LSR_SHIFT_EMPTY) : 8'h00;
              if (!fifo_stat.empty) begin
                rd = rd | LSR_DR;
              end
            end
            REG_MSR: rd = 8'h00;
            REG_SCR: rd = scratch;
            default: rd = 8'h00;
          endcase
        end
      end
      default: ;
    endcase

    rx_pending_next = (fifo_ctrl.push && !fifo_stat.full)
                   || (!fifo_stat.empty && !(fifo_ctrl.pop && fifo_stat.one));
    irq_next = (int_enable_next[0] && rx_pending_next) || (int_enable_next[1] && tx_idle_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable    <= '0;
      line_control  <= '0;
      modem_control <= '0;
      scratch       <= '0;
      tx_idle       <= 1'b1;
      rsp.valid     <= 1'b0;
    end else begin
      if (s1_advance) begin
        int_enable    <= int_enable_next;
        line_control  <= line_control_next;
        modem_control <= modem_control_next;
        scratch       <= scratch_next;
        tx_idle       <= tx_idle_next;
        rsp.valid     <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (s1_advance) begin
      rsp.read_data  <= rd;
      rsp.addr_error <= aerr;
      rsp.tx_valid   <= txv;
      rsp.tx_byte    <= txb;
      rsp.irq        <= irq_next;
    end
  end

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.addr_error |-> rsp.read_data == 8'h00 && !rsp.tx_valid)
    else $error("address error response carries data");

  a_tx_no_err: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.tx_valid |-> !rsp.addr_error && rsp.read_data == 8'h00)
    else $error("transmit response carries read data or error");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    s1_advance && fifo_ctrl.pop && fifo_stat.empty |=> rsp.read_data == 8'h00)
    else $error("read of empty receive FIFO returned data");

  a_tx_idle: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> tx_idle)
    else $error("transmitter idle flag dropped");

endmodule

/* sv/u16550_rx_fifo.sv */
// Receive FIFO: circular byte memory with head pointer, fill count and head prefetch.
// Depends on u16550_pkg.
module u16550_rx_fifo
  import u16550_pkg::*;
#(
  parameter int RX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctrl_t ctrl,
  output fifo_stat_t stat
);

  localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CW = $clog2(RX_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(RX_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(RX_DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(RX_DEPTH - 1);

  logic [7:0]    mem [RX_DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic          push_ok;
  logic          pop_ok;
  logic [7:0]    rd_q;
  logic          byp;
  logic [7:0]    byp_data;

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == DEPTH_C);
  assign stat.one       = (count == CW'(1));
  assign stat.head_byte = byp ? byp_data : rd_q;

  assign push_ok = ctrl.push && !stat.full;
  assign pop_ok  = ctrl.pop && !stat.empty;

  always_comb begin
    tail_sum = (AW + 1)'(head) + (AW + 1)'(count);
    if (tail_sum >= DEPTH_W) begin
      tail_sum = tail_sum - DEPTH_W;
    end
    tail = tail_sum[AW-1:0];

    head_next = head;
    if (pop_ok) begin
      head_next = (head == LAST_IX) ? '0 : head + AW'(1);
    end

    count_next = count;
    if (push_ok) begin
      count_next = count + CW'(1);
    end else if (pop_ok) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= ctrl.wdata;
    end
    rd_q     <= mem[head_next];
    byp      <= push_ok && (tail == head_next);
    byp_data <= ctrl.wdata;
  end

endmodule
